@@ hdl/ols_pkg.sv @@
package ols_pkg;

  // command codes
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_SEARCH  = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_INS_PUT,
    ST_DEL_RD,
    ST_DEL_CAP,
    ST_SHL_RD,
    ST_SHL_WR,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_REV_RDLO,
    ST_REV_RDHI,
    ST_REV_WRLO,
    ST_REV_WRHI,
    ST_DONE
  } state_t;

endpackage

@@ hdl/ordered_list_store.sv @@
// channel | direction | handshake             | payload
// in_     | input     | in_valid / in_ready   | command, position, value
// out_    | output    | out_valid / out_ready | status, removed_value, found_position, length
//
// One beat at a time: in_ready is high only while the sequencer is idle.
// All element moves go through one RAM with a single registered read port:
// insert/delete read and write each shifted element in turn, search reads and
// compares each element, reverse reads both ends of a pair and writes them back.
// A finished result waits in the output register; a new beat is taken meanwhile.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
module ordered_list_store
  import ols_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam logic [8:0] CAP9 = 9'(CAPACITY);

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   tmp_r, tmp_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [31:0]   removed_r, removed_nxt;
  logic [7:0]    found_r, found_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [31:0]   out_removed_r, out_removed_nxt;
  logic [7:0]    out_found_r, out_found_nxt;
  logic [7:0]    out_length_r, out_length_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          accept;
  logic          out_free;
  logic [8:0]    n9, k9, hi9, p9, ip9;
  logic [7:0]    pos_m1;
  logic          ins_bad, del_bad, full;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign n9       = 9'(count_r);
  assign k9       = 9'(k_r);
  assign hi9      = 9'(hi_r);
  assign p9       = {1'b0, pos_r};
  assign ip9      = {1'b0, in_position};
  assign pos_m1   = pos_r - 8'd1;
  assign ins_bad  = (in_position == 8'd0) || (ip9 > n9 + 9'd1);
  assign del_bad  = (in_position == 8'd0) || (ip9 > n9);
  assign full     = (n9 == CAP9);

  ols_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            CMD_INSERT: begin
              if (ins_bad || full) begin
                state_nxt = ST_DONE;
              end else if (n9 >= ip9) begin
                state_nxt = ST_INS_RD;
              end else begin
                state_nxt = ST_INS_PUT;
              end
            end
            CMD_DELETE:  state_nxt = del_bad ? ST_DONE : ST_DEL_RD;
            CMD_SEARCH:  state_nxt = (count_r == '0) ? ST_DONE : ST_SRCH_RD;
            CMD_REVERSE: state_nxt = (n9 > 9'd1) ? ST_REV_RDLO : ST_DONE;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INS_RD:   state_nxt = ST_INS_WR;
      ST_INS_WR:   state_nxt = (k9 > p9) ? ST_INS_RD : ST_INS_PUT;
      ST_INS_PUT:  state_nxt = ST_DONE;
      ST_DEL_RD:   state_nxt = ST_DEL_CAP;
      ST_DEL_CAP:  state_nxt = (p9 < n9) ? ST_SHL_RD : ST_DONE;
      ST_SHL_RD:   state_nxt = ST_SHL_WR;
      ST_SHL_WR:   state_nxt = (k9 + 9'd1 < n9) ? ST_SHL_RD : ST_DONE;
      ST_SRCH_RD:  state_nxt = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        if (ram_rdata != val_r && k9 + 9'd1 < n9) begin
          state_nxt = ST_SRCH_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_REV_RDLO: state_nxt = ST_REV_RDHI;
      ST_REV_RDHI: state_nxt = ST_REV_WRLO;
      ST_REV_WRLO: state_nxt = ST_REV_WRHI;
      ST_REV_WRHI: state_nxt = (k9 + 9'd2 < hi9) ? ST_REV_RDLO : ST_DONE;
      ST_DONE:     state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = k_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = k_r[AW-1:0];
    unique case (state_r)
      ST_INS_RD:   ram_raddr = AW'(k9 - 9'd1);
      ST_INS_WR:   ram_we = 1'b1;
      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_m1[AW-1:0];
        ram_wdata = val_r;
      end
      ST_DEL_RD:   ram_raddr = pos_m1[AW-1:0];
      ST_SHL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(k9 - 9'd1);
      end
      ST_REV_RDHI: ram_raddr = hi_r[AW-1:0];
      ST_REV_WRLO: ram_we = 1'b1;
      ST_REV_WRHI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_r[AW-1:0];
        ram_wdata = tmp_r;
      end
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    count_nxt   = count_r;
    k_nxt       = k_r;
    hi_nxt      = hi_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    tmp_nxt     = tmp_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    found_nxt   = found_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pos_nxt     = in_position;
          val_nxt     = in_value;
          status_nxt  = STAT_OK;
          removed_nxt = '0;
          found_nxt   = '0;
          k_nxt       = '0;
          hi_nxt      = CW'(n9 - 9'd1);
          unique case (in_command)
            CMD_CLEAR: count_nxt = '0;
            CMD_INSERT: begin
              k_nxt = count_r;
              if (ins_bad) begin
                status_nxt = STAT_BAD_POS;
              end else if (full) begin
                status_nxt = STAT_FULL;
              end
            end
            CMD_DELETE: begin
              if (del_bad) begin
                status_nxt = STAT_BAD_POS;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INS_WR:  k_nxt = CW'(k9 - 9'd1);
      ST_INS_PUT: count_nxt = CW'(n9 + 9'd1);
      ST_DEL_CAP: begin
        removed_nxt = ram_rdata;
        k_nxt       = CW'(p9);
        if (!(p9 < n9)) begin
          count_nxt = CW'(n9 - 9'd1);
        end
      end
      ST_SHL_WR: begin
        k_nxt = CW'(k9 + 9'd1);
        if (!(k9 + 9'd1 < n9)) begin
          count_nxt = CW'(n9 - 9'd1);
        end
      end
      ST_SRCH_CMP: begin
        if (ram_rdata == val_r) begin
          found_nxt = 8'(k9 + 9'd1);
        end else begin
          k_nxt = CW'(k9 + 9'd1);
        end
      end
      ST_REV_RDHI: tmp_nxt = ram_rdata;
      ST_REV_WRHI: begin
        k_nxt  = CW'(k9 + 9'd1);
        hi_nxt = CW'(hi9 - 9'd1);
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_found_nxt   = out_found_r;
    out_length_nxt  = out_length_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_DONE && out_free) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = status_r;
      out_removed_nxt = removed_r;
      out_found_nxt   = found_r;
      out_length_nxt  = 8'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    hi_r          <= hi_nxt;
    pos_r         <= pos_nxt;
    val_r         <= val_nxt;
    tmp_r         <= tmp_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    found_r       <= found_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_found_r   <= out_found_nxt;
    out_length_r  <= out_length_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_removed_value  = out_removed_r;
  assign out_found_position = out_found_r;
  assign out_length         = out_length_r;

endmodule

@@ hdl/ols_ram.sv @@
module ols_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ols_checker.sv @@
module ols_checker
  import ols_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_removed_value,
  input logic [7:0]         out_found_position,
  input logic [7:0]         out_length
);

  // stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  // stalled result length and status hold
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_length) && $stable(out_status))
    else $error("result payload changed while stalled");

  // no new beat is taken right after an accepted one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // full status only when the list is at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_length == 8'(CAPACITY))
    else $error("full status with list below capacity");

  // a match lies within the list, with status OK and a zero removed value
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_position != 8'd0 |->
      out_found_position <= out_length && out_removed_value == 32'sd0 &&
      out_status == STAT_OK)
    else $error("found position outside the list");

endmodule

bind ordered_list_store ols_checker #(.CAPACITY(CAPACITY)) u_ols_checker (.*);
